// File: rtl/kci_pkg.sv
// Shared types and constants for the keyed colour interpolator.
// No dependencies; every other file in rtl/ refers to this package.
`default_nettype none

package kci_pkg;

	localparam int POS_W = 16;   // Q4.12 key and fraction width
	localparam int COL_W = 16;   // Q0.16 colour component width
	localparam int T_W   = 16;   // Q0.16 blend weight width

	// input word action codes
	localparam logic ACT_LOAD = 1'b0;
	localparam logic ACT_EVAL = 1'b1;

	// colour channel select codes
	localparam logic [1:0] CH_R = 2'd0;
	localparam logic [1:0] CH_G = 2'd1;
	localparam logic [1:0] CH_B = 2'd2;
	localparam logic [1:0] CH_LAST = 2'd3;

	typedef struct packed {
		logic [COL_W-1:0] r;
		logic [COL_W-1:0] g;
		logic [COL_W-1:0] b;
	} rgb_t;

endpackage

`default_nettype wire

// File: rtl/kci_if.sv
// Valid/ready channel interfaces for the interpolator's input and result words.
// Depends on kci_pkg for field widths.
`default_nettype none

interface kci_in_if;
	logic                              valid;
	logic                              ready;
	logic                              action;
	logic [3:0]                        entry_index;
	logic signed [kci_pkg::POS_W-1:0]  key_position;
	logic [kci_pkg::COL_W-1:0]         red_in;
	logic [kci_pkg::COL_W-1:0]         green_in;
	logic [kci_pkg::COL_W-1:0]         blue_in;
	logic signed [kci_pkg::POS_W-1:0]  fraction;

	modport source (
		output valid, action, entry_index, key_position, red_in, green_in, blue_in,
			fraction,
		input  ready
	);
	modport sink (
		input  valid, action, entry_index, key_position, red_in, green_in, blue_in,
			fraction,
		output ready
	);
endinterface

interface kci_out_if;
	logic                      valid;
	logic                      ready;
	logic [kci_pkg::COL_W-1:0] red_out;
	logic [kci_pkg::COL_W-1:0] green_out;
	logic [kci_pkg::COL_W-1:0] blue_out;

	modport source (
		output valid, red_out, green_out, blue_out,
		input  ready
	);
	modport sink (
		input  valid, red_out, green_out, blue_out,
		output ready
	);
endinterface

`default_nettype wire

// File: rtl/kci_table.sv
// Key and colour store: one write port, one shared read address, registered read.
// Depends on kci_pkg (rgb_t, POS_W).
`default_nettype none

module kci_table #(
	parameter int MAX_KEYS = 16
) (
	input  wire                                  clk,
	input  wire                                  wr_en,
	input  wire [$clog2(MAX_KEYS)-1:0]           wr_addr,
	input  wire [kci_pkg::POS_W-1:0]             wr_key,
	input  kci_pkg::rgb_t                        wr_col,
	input  wire [$clog2(MAX_KEYS)-1:0]           rd_addr,
	output logic [kci_pkg::POS_W-1:0]            key_rd,
	output kci_pkg::rgb_t                        col_rd
);

	logic [kci_pkg::POS_W-1:0] key_mem [MAX_KEYS];
	kci_pkg::rgb_t             col_mem [MAX_KEYS];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			key_mem[wr_addr] <= wr_key;
			col_mem[wr_addr] <= wr_col;
		end
	end

	always_ff @(posedge clk) begin
		key_rd <= key_mem[rd_addr];
		col_rd <= col_mem[rd_addr];
	end

endmodule

`default_nettype wire

// File: rtl/kci_div.sv
// Restoring divider, one quotient bit per cycle: quot = (num << 16) / den.
// Needs num < den. Depends on kci_pkg (T_W).
`default_nettype none

module kci_div (
	input  wire                       clk,
	input  wire                       arst_n,
	input  wire                       start,
	input  wire [kci_pkg::T_W-1:0]    num,
	input  wire [kci_pkg::T_W-1:0]    den,
	output logic                      done,
	output logic [kci_pkg::T_W-1:0]   quot
);

	localparam int CNT_W = $clog2(kci_pkg::T_W + 1);

	logic [kci_pkg::T_W-1:0] rem_q;
	logic [kci_pkg::T_W-1:0] den_q;
	logic [kci_pkg::T_W-1:0] quo_q;
	logic [CNT_W-1:0]        cnt_q;
	logic                    busy_q;
	logic                    done_q;

	logic [kci_pkg::T_W:0]   rem_sh;
	logic [kci_pkg::T_W:0]   rem_sub;
	logic                    fits;

	// remainder stays below den, so the shifted value stays below 2*den
	always_comb begin
		rem_sh  = {rem_q, 1'b0};
		rem_sub = rem_sh - {1'b0, den_q};
		fits    = (rem_sh >= {1'b0, den_q});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(kci_pkg::T_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= num;
			den_q <= den;
			quo_q <= '0;
		end else if (busy_q) begin
			rem_q <= fits ? rem_sub[kci_pkg::T_W-1:0] : rem_sh[kci_pkg::T_W-1:0];
			quo_q <= {quo_q[kci_pkg::T_W-2:0], fits};
		end
	end

	assign done = done_q;
	assign quot = quo_q;

endmodule

`default_nettype wire

// File: rtl/kci_mix.sv
// Colour blend with one shared multiplier: out = c0 + floor((c1 - c0) * t / 2^16),
// one channel per cycle, product registered before the add. Depends on kci_pkg.
`default_nettype none

module kci_mix (
	input  wire                       clk,
	input  wire                       arst_n,
	input  wire                       start,
	input  kci_pkg::rgb_t             c0,
	input  kci_pkg::rgb_t             c1,
	input  wire [kci_pkg::T_W-1:0]    t,
	output logic                      done,
	output kci_pkg::rgb_t             res
);

	localparam int PROD_W = kci_pkg::COL_W + kci_pkg::T_W + 2;

	kci_pkg::rgb_t             c0_q;
	kci_pkg::rgb_t             c1_q;
	logic [kci_pkg::T_W-1:0]   t_q;
	logic [1:0]                step_q;
	logic                      busy_q;
	logic                      done_q;
	logic signed [PROD_W-1:0]  prod_s1;
	kci_pkg::rgb_t             res_q;

	logic signed [kci_pkg::COL_W:0] diff;
	logic signed [PROD_W-1:0]       mult;
	logic [1:0]                     prev;
	logic [kci_pkg::COL_W-1:0]      sum;

	function automatic logic [kci_pkg::COL_W-1:0] chan(input kci_pkg::rgb_t c,
			input logic [1:0] k);
		case (k)
			kci_pkg::CH_R: chan = c.r;
			kci_pkg::CH_G: chan = c.g;
			default:       chan = c.b;
		endcase
	endfunction

	always_comb begin
		diff = $signed({1'b0, chan(c1_q, step_q)}) - $signed({1'b0, chan(c0_q, step_q)});
		mult = diff * $signed({1'b0, t_q});
		prev = step_q - 1'b1;
		// the blend lies between c0 and c1, so the low 16 bits of the sum are exact
		sum  = chan(c0_q, prev) + prod_s1[kci_pkg::COL_W+kci_pkg::T_W-1:kci_pkg::T_W];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= kci_pkg::CH_R;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= kci_pkg::CH_R;
			end else if (busy_q) begin
				step_q <= step_q + 1'b1;
				if (step_q == kci_pkg::CH_LAST) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			c0_q <= c0;
			c1_q <= c1;
			t_q  <= t;
		end else if (busy_q) begin
			prod_s1 <= mult;
			if (step_q != kci_pkg::CH_R) begin
				case (prev)
					kci_pkg::CH_R: res_q.r <= sum;
					kci_pkg::CH_G: res_q.g <= sum;
					default:       res_q.b <= sum;
				endcase
			end
		end
	end

	assign done = done_q;
	assign res  = res_q;

endmodule

`default_nettype wire

// File: rtl/keyed_color_linear_interpolator.sv
// Keyed colour interpolator: a table of up to MAX_KEYS (key, RGB) entries and
// a piecewise-linear colour lookup between neighbouring keys.
// Channels: item (valid/ready sink) carries load and evaluate words; result
// (valid/ready source) carries one interpolated colour per evaluate. A load
// writes one entry in the accept cycle and gives no result; an evaluate with
// key_count of zero gives none either. cfg_we/cfg_wdata write key_count; the
// user must write them only while the block is idle; it does not enforce this.
// Timing: item.ready is high only while the sequencer is idle, so one word is
// in flight at a time. An evaluate runs the accept, a key scan (at most the
// key count of keys read), the divider (skipped when the fraction lies below
// the first key or at or above the last), two colour reads, the blend and the
// output load. Scan speed is set by the single read port of the table; the
// divider yields one quotient bit a cycle; the blend shares one multiplier
// over the three channels.
// The result sits in an output register; the next word is accepted while it
// waits. If the receiver stalls, a finished evaluate waits in the final state
// until the register is free. Reset clears key_count, the sequencer and the
// result valid; table contents are undefined until loaded.
`default_nettype none

module keyed_color_linear_interpolator #(
	parameter int MAX_KEYS = 16
) (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         cfg_we,
	input  wire [4:0]   cfg_wdata,
	kci_in_if.sink      item,
	kci_out_if.source   result
);

	localparam int ADDR_W = $clog2(MAX_KEYS);
	localparam int CNT_W  = $clog2(MAX_KEYS + 1);

	// sequencer states
	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_SCAN  = 3'd1;
	localparam logic [2:0] S_DIV   = 3'd2;
	localparam logic [2:0] S_RDL   = 3'd3;
	localparam logic [2:0] S_RDR   = 3'd4;
	localparam logic [2:0] S_MIXGO = 3'd5;
	localparam logic [2:0] S_MIXW  = 3'd6;
	localparam logic [2:0] S_OUT   = 3'd7;

	logic [2:0]                        state_q, state_d;
	logic [4:0]                        key_count_q;
	logic signed [kci_pkg::POS_W-1:0]  frac_q;
	logic [CNT_W-1:0]                  n_q;
	logic [CNT_W-1:0]                  idx_q;
	logic                              found_q;
	logic [ADDR_W-1:0]                 left_q;
	logic [ADDR_W-1:0]                 right_q;
	logic [kci_pkg::POS_W-1:0]         kl_q;
	logic [kci_pkg::T_W-1:0]           t_q;
	kci_pkg::rgb_t                     c0_q;
	kci_pkg::rgb_t                     out_q;
	logic                              out_valid_q;

	logic                              in_acc;
	logic [31:0]                       n_full;
	logic [CNT_W-1:0]                  n_cur;
	logic [31:0]                       widx_ext;
	logic                              wr_en;
	logic [CNT_W-1:0]                  idx_nx;
	logic [ADDR_W-1:0]                 idx_addr;
	logic [ADDR_W-1:0]                 rd_addr;
	logic                              key_le;
	logic                              scan_last;
	logic                              out_free;
	logic                              div_start;
	logic                              mix_start;
	logic [kci_pkg::T_W-1:0]           div_num;
	logic [kci_pkg::T_W-1:0]           div_den;
	logic                              div_done;
	logic [kci_pkg::T_W-1:0]           div_quot;
	logic                              mix_done;
	kci_pkg::rgb_t                     mix_res;
	logic [kci_pkg::POS_W-1:0]         key_rd;
	kci_pkg::rgb_t                     col_rd;
	kci_pkg::rgb_t                     wr_col;

	assign item.ready = (state_q == S_IDLE);
	assign in_acc     = item.valid && item.ready;

	// entries in use, clamped to the table depth
	always_comb begin
		n_full = (32'(key_count_q) > 32'(MAX_KEYS)) ? 32'(MAX_KEYS) : 32'(key_count_q);
		n_cur  = n_full[CNT_W-1:0];
	end

	// load words beyond the table are dropped
	assign widx_ext = 32'(item.entry_index);
	assign wr_en    = in_acc && (item.action == kci_pkg::ACT_LOAD)
		&& (widx_ext < 32'(MAX_KEYS));
	assign wr_col   = '{r: item.red_in, g: item.green_in, b: item.blue_in};

	assign idx_nx    = idx_q + 1'b1;
	assign idx_addr  = idx_q[ADDR_W-1:0];
	assign key_le    = ($signed(key_rd) <= frac_q);
	assign scan_last = (idx_q == n_q - 1'b1);
	assign out_free  = !out_valid_q || result.ready;

	// left key <= fraction < right key, so the numerator is not negative and the denominator is positive
	assign div_num = frac_q - kl_q;
	assign div_den = key_rd - kl_q;

	always_comb begin
		state_d   = state_q;
		rd_addr   = '0;
		div_start = 1'b0;
		mix_start = 1'b0;
		case (state_q)
			S_IDLE: begin
				if (in_acc && (item.action == kci_pkg::ACT_EVAL) && (n_cur != '0)) begin
					state_d = S_SCAN;
				end
			end
			S_SCAN: begin
				// key_rd holds entry idx_q here
				if (key_le) begin
					if (scan_last) begin
						state_d = S_RDL;
					end else begin
						rd_addr = idx_nx[ADDR_W-1:0];
					end
				end else if (found_q) begin
					div_start = 1'b1;
					state_d   = S_DIV;
				end else begin
					state_d = S_RDL;
				end
			end
			S_DIV: begin
				if (div_done) begin
					state_d = S_RDL;
				end
			end
			S_RDL: begin
				rd_addr = left_q;
				state_d = S_RDR;
			end
			S_RDR: begin
				rd_addr = right_q;
				state_d = S_MIXGO;
			end
			S_MIXGO: begin
				mix_start = 1'b1;
				state_d   = S_MIXW;
			end
			S_MIXW: begin
				if (mix_done) begin
					state_d = S_OUT;
				end
			end
			S_OUT: begin
				if (out_free) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			key_count_q <= '0;
			out_valid_q <= 1'b0;
			found_q     <= 1'b0;
			idx_q       <= '0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				key_count_q <= cfg_wdata;
			end
			// a new result may replace the one leaving in the same cycle
			if ((state_q == S_OUT) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (result.valid && result.ready) begin
				out_valid_q <= 1'b0;
			end
			if (state_q == S_IDLE) begin
				idx_q   <= '0;
				found_q <= 1'b0;
			end else if ((state_q == S_SCAN) && key_le) begin
				found_q <= 1'b1;
				if (!scan_last) begin
					idx_q <= idx_nx;
				end
			end
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (in_acc) begin
			frac_q <= item.fraction;
			n_q    <= n_cur;
		end
		case (state_q)
			S_SCAN: begin
				if (key_le) begin
					kl_q   <= key_rd;
					left_q <= idx_addr;
					if (scan_last) begin
						right_q <= idx_addr;
						t_q     <= '0;
					end
				end else if (found_q) begin
					right_q <= idx_addr;
				end else begin
					// fraction below the first key: first colour
					left_q  <= '0;
					right_q <= '0;
					t_q     <= '0;
				end
			end
			S_DIV: begin
				if (div_done) begin
					t_q <= div_quot;
				end
			end
			S_RDR: begin
				c0_q <= col_rd;
			end
			S_OUT: begin
				if (out_free) begin
					out_q <= mix_res;
				end
			end
			default: begin
			end
		endcase
	end

	kci_table #(
		.MAX_KEYS (MAX_KEYS)
	) u_table (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (widx_ext[ADDR_W-1:0]),
		.wr_key  (item.key_position),
		.wr_col  (wr_col),
		.rd_addr (rd_addr),
		.key_rd  (key_rd),
		.col_rd  (col_rd)
	);

	kci_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (div_den),
		.done   (div_done),
		.quot   (div_quot)
	);

	kci_mix u_mix (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mix_start),
		.c0     (c0_q),
		.c1     (col_rd),
		.t      (t_q),
		.done   (mix_done),
		.res    (mix_res)
	);

	assign result.valid     = out_valid_q;
	assign result.red_out   = out_q.r;
	assign result.green_out = out_q.g;
	assign result.blue_out  = out_q.b;

endmodule

`default_nettype wire
